[rtl/core/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int IDX_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_DW   = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CELL_DW-1:0] BLANK_CELL  = {BLANK_ATTR, BLANK_CHAR};

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        CMD_CHAR      = 2'd0,
        CMD_NEWLINE   = 2'd1,
        CMD_READ      = 2'd2,
        CMD_READ_NULL = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [IDX_W-1:0]  index;
    } cmd_t;

endpackage

[rtl/core/tcw_front.sv]
// ---------------------------------------------------------------------------
// tcw_front
// Request intake: holds the attribute register and sorts each request
// into a console command for the queue.
// ---------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    input  logic                          text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    text_attribute_data,
    input  logic                          queue_full,
    input  logic                          clearing,
    output logic                          push,
    output tcw_pkg::cmd_t                 cmd
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CUR_W = $clog2(CELLS + 1);
    localparam int CMP_W = (CUR_W > IDX_W) ? CUR_W : IDX_W;

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;
    logic [CMP_W-1:0]  idx_ext;
    logic              in_range;

    always_comb
    begin
        attr_next = text_attribute_we ? text_attribute_data : attr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    assign idx_ext    = CMP_W'(cell_index);
    assign in_range   = idx_ext < CMP_W'(CELLS);
    assign item_stall = queue_full | clearing;
    assign push       = item_valid & ~item_stall;

    always_comb
    begin
        cmd.ch    = char_code;
        cmd.attr  = attr_reg;
        cmd.index = cell_index;
        if (op == OP_READ)
        begin
            cmd.kind = in_range ? CMD_READ : CMD_READ_NULL;
        end
        else if (char_code == NEWLINE_CODE)
        begin
            cmd.kind = CMD_NEWLINE;
        end
        else
        begin
            cmd.kind = CMD_CHAR;
        end
    end

endmodule

[rtl/core/tcw_queue.sv]
// ---------------------------------------------------------------------------
// tcw_queue
// Short command queue between intake and the screen engine.
// ---------------------------------------------------------------------------
module tcw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcw_pkg::cmd_t push_data,
    input  logic          pop,
    output tcw_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import tcw_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/tcw_back.sv]
// ---------------------------------------------------------------------------
// tcw_back
// Screen engine: owns the screen RAM and cursor, runs the power-up clear,
// the scroll sweep, cell writes and reads, and the result register.
// ---------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       queue_empty,
    input  tcw_pkg::cmd_t              queue_data,
    output logic                       pop,
    output logic                       clearing,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [tcw_pkg::CHAR_W-1:0] cell_char,
    output logic [tcw_pkg::ATTR_W-1:0] cell_attribute,
    output logic [tcw_pkg::IDX_W-1:0]  cursor_position,
    output logic                       scrolled
);
    import tcw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CUR_W  = $clog2(CELLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int KEEP   = CELLS - COLUMNS;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_RDWAIT = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CUR_W-1:0]   cnt_reg;
    logic [CUR_W-1:0]   cnt_next;
    logic [CUR_W-1:0]   cursor_reg;
    logic [CUR_W-1:0]   cursor_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               scroll_flag_reg;
    logic               scroll_flag_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [CHAR_W-1:0]  res_char_reg;
    logic [CHAR_W-1:0]  res_char_next;
    logic [ATTR_W-1:0]  res_attr_reg;
    logic [ATTR_W-1:0]  res_attr_next;
    logic [CUR_W-1:0]   res_cursor_reg;
    logic [CUR_W-1:0]   res_cursor_next;
    logic               res_scrolled_reg;
    logic               res_scrolled_next;

    logic [CELL_DW-1:0] screen_mem [CELLS];
    logic [CELL_DW-1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_DW-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               out_free;
    logic               at_end;

    assign out_free = ~res_valid_reg | ~result_stall;
    assign at_end   = cursor_reg == CUR_W'(CELLS);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cursor_next       = cursor_reg;
        col_next          = col_reg;
        scroll_flag_next  = scroll_flag_reg;
        cmd_next          = cmd_reg;
        res_valid_next    = res_valid_reg & result_stall;
        res_char_next     = res_char_reg;
        res_attr_next     = res_attr_reg;
        res_cursor_next   = res_cursor_reg;
        res_scrolled_next = res_scrolled_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = BLANK_CELL;
        mem_re            = 1'b0;
        mem_raddr         = '0;
        pop               = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                if (cnt_reg == CUR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CUR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop              = 1'b1;
                    cmd_next         = queue_data;
                    scroll_flag_next = 1'b0;
                    state_next       = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((cmd_reg.kind == CMD_CHAR || cmd_reg.kind == CMD_NEWLINE) && at_end)
                begin
                    cnt_next         = '0;
                    scroll_flag_next = 1'b1;
                    state_next       = ST_SCROLL;
                end
                else if (out_free)
                begin
                    res_char_next     = '0;
                    res_attr_next     = '0;
                    res_scrolled_next = scroll_flag_reg;
                    case (cmd_reg.kind)
                        CMD_CHAR:
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = ADDR_W'(cursor_reg);
                            mem_wdata   = {cmd_reg.attr, cmd_reg.ch};
                            cursor_next = cursor_reg + CUR_W'(1);
                            col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                           : col_reg + COL_W'(1);
                            res_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        CMD_NEWLINE:
                        begin
                            cursor_next    = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
                            col_next       = '0;
                            res_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = ADDR_W'(cmd_reg.index);
                            state_next = ST_RDWAIT;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    endcase
                    res_cursor_next = cursor_next;
                end
            end
            ST_RDWAIT:
            begin
                res_valid_next    = 1'b1;
                res_char_next     = rd_data_reg[CHAR_W-1:0];
                res_attr_next     = rd_data_reg[CELL_DW-1:CHAR_W];
                res_cursor_next   = cursor_reg;
                res_scrolled_next = 1'b0;
                state_next        = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the previous read one cell behind
                if (cnt_reg < CUR_W'(KEEP))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(cnt_reg + CUR_W'(COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(cnt_reg - CUR_W'(1));
                    mem_wdata = (cnt_reg <= CUR_W'(KEEP)) ? rd_data_reg : BLANK_CELL;
                end
                if (cnt_reg == CUR_W'(CELLS))
                begin
                    cnt_next    = '0;
                    cursor_next = CUR_W'(KEEP);
                    col_next    = '0;
                    state_next  = ST_EXEC;
                end
                else
                begin
                    cnt_next = cnt_reg + CUR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cnt_reg         <= '0;
            cursor_reg      <= '0;
            col_reg         <= '0;
            scroll_flag_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cursor_reg      <= cursor_next;
            col_reg         <= col_next;
            scroll_flag_reg <= scroll_flag_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        res_char_reg     <= res_char_next;
        res_attr_reg     <= res_attr_next;
        res_cursor_reg   <= res_cursor_next;
        res_scrolled_reg <= res_scrolled_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    assign clearing        = state_reg == ST_CLEAR;
    assign result_valid    = res_valid_reg;
    assign cell_char       = res_char_reg;
    assign cell_attribute  = res_attr_reg;
    assign cursor_position = IDX_W'(res_cursor_reg);
    assign scrolled        = res_scrolled_reg;

endmodule

[rtl/core/text_console_writer_top.sv]
// ---------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console with scroll-up, one result per request.
// ---------------------------------------------------------------------------
// After reset the screen RAM is cleared to blanks one cell per cycle;
// requests are stalled meanwhile. The screen engine then sets the pace: a
// character write, newline or out-of-range read passes through the execute
// state, an in-range read also through a wait state for the registered RAM
// read. A write with the cursor at the end of the screen first runs a
// scroll sweep over the whole RAM. A two-entry command queue lets intake
// keep taking requests while the engine works.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       op,
    input  logic [tcw_pkg::CHAR_W-1:0] char_code,
    input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
    input  logic                       text_attribute_we,
    input  logic [tcw_pkg::ATTR_W-1:0] text_attribute_data,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [tcw_pkg::CHAR_W-1:0] cell_char,
    output logic [tcw_pkg::ATTR_W-1:0] cell_attribute,
    output logic [tcw_pkg::IDX_W-1:0]  cursor_position,
    output logic                       scrolled
);
    import tcw_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    logic clearing;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_stall          (item_stall),
        .op                  (op),
        .char_code           (char_code),
        .cell_index          (cell_index),
        .text_attribute_we   (text_attribute_we),
        .text_attribute_data (text_attribute_data),
        .queue_full          (queue_full),
        .clearing            (clearing),
        .push                (push),
        .cmd                 (push_cmd)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (head_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .queue_data      (head_cmd),
        .pop             (pop),
        .clearing        (clearing),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .cell_char       (cell_char),
        .cell_attribute  (cell_attribute),
        .cursor_position (cursor_position),
        .scrolled        (scrolled)
    );

endmodule

[test/text_console_writer_top_tb.sv]
// ---------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking bench for the text console writer. A shadow screen and
// cursor predict every reply. A short directed run covers blank reads, the
// extreme character codes, newlines mid-row and at a row start, scrolls
// started by a character and by a newline, and reads past the screen. It is
// followed by random bursts under changing attributes and back-pressure.
// ---------------------------------------------------------------------------
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int BURSTS     = 18;
    localparam int BURST_LEN  = 95;

    typedef struct packed {
        logic              opv;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } console_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [IDX_W-1:0]  cursor;
        logic              scrolled;
    } console_reply_t;

    logic               clk                 = 1'b0;
    logic               rst_n               = 1'b0;
    logic               item_valid          = 1'b0;
    logic               item_stall;
    logic               op                  = OP_WRITE;
    logic [CHAR_W-1:0]  char_code           = '0;
    logic [IDX_W-1:0]   cell_index          = '0;
    logic               text_attribute_we   = 1'b0;
    logic [ATTR_W-1:0]  text_attribute_data = '0;
    logic               result_valid;
    logic               result_stall        = 1'b0;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attribute;
    logic [IDX_W-1:0]   cursor_position;
    logic               scrolled;

    console_req_t       console_req_q[$];
    console_reply_t     console_reply_q[$];

    logic [CELL_DW-1:0] shadow_screen [0:CELL_COUNT-1];
    int unsigned        shadow_cursor;
    logic [ATTR_W-1:0]  shadow_attr;

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        error_count   = 0;
    int unsigned        write_count   = 0;
    int unsigned        newline_count = 0;
    int unsigned        read_count    = 0;
    int unsigned        oob_count     = 0;
    int unsigned        scroll_count  = 0;
    int unsigned        attr_count    = 0;

    text_console_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_valid          (item_valid),
        .item_stall          (item_stall),
        .op                  (op),
        .char_code           (char_code),
        .cell_index          (cell_index),
        .text_attribute_we   (text_attribute_we),
        .text_attribute_data (text_attribute_data),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .cell_char           (cell_char),
        .cell_attribute      (cell_attribute),
        .cursor_position     (cursor_position),
        .scrolled            (scrolled)
    );

    always #5 clk = ~clk;

    function automatic console_reply_t console_step(console_req_t req);
        console_reply_t r;
        r = '0;
        if (req.opv == OP_WRITE)
        begin
            if (shadow_cursor >= CELL_COUNT)
            begin
                for (int k = 0; k < CELL_COUNT - COLUMNS; k++)
                    shadow_screen[k] = shadow_screen[k + COLUMNS];
                for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++)
                    shadow_screen[k] = BLANK_CELL;
                shadow_cursor = CELL_COUNT - COLUMNS;
                r.scrolled    = 1'b1;
                scroll_count++;
            end
            if (req.ch == NEWLINE_CODE)
            begin
                shadow_cursor += COLUMNS - (shadow_cursor % COLUMNS);
                newline_count++;
            end
            else
            begin
                shadow_screen[shadow_cursor] = {shadow_attr, req.ch};
                shadow_cursor++;
                write_count++;
            end
        end
        else
        begin
            read_count++;
            if (req.idx < CELL_COUNT)
            begin
                r.ch   = shadow_screen[req.idx][CHAR_W-1:0];
                r.attr = shadow_screen[req.idx][CELL_DW-1:CHAR_W];
            end
            else
                oob_count++;
        end
        r.cursor = IDX_W'(shadow_cursor);
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        console_req_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            op         <= OP_WRITE;
            char_code  <= '0;
            cell_index <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                console_reply_q.push_back(console_step({op, char_code, cell_index}));
            if (!item_valid || !item_stall)
            begin
                if (console_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt        = console_req_q.pop_front();
                    item_valid <= 1'b1;
                    op         <= nxt.opv;
                    char_code  <= nxt.ch;
                    cell_index <= nxt.idx;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    task automatic report_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    // reply monitor
    always @(posedge clk or negedge rst_n)
    begin
        console_reply_t exp_r;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (console_reply_q.size() == 0)
                begin
                    $display("%0t: reply with none expected, cursor %0d", $time,
                             cursor_position);
                    error_count++;
                end
                else
                begin
                    exp_r = console_reply_q.pop_front();
                    report_field("cell_char", exp_r.ch, cell_char);
                    report_field("cell_attribute", exp_r.attr, cell_attribute);
                    report_field("cursor_position", exp_r.cursor, cursor_position);
                    report_field("scrolled", exp_r.scrolled, scrolled);
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic queue_request(logic opv, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        console_req_q.push_back({opv, ch, idx});
    endtask

    task automatic drain();
        while (console_req_q.size() != 0 || item_valid || console_reply_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_attribute(logic [ATTR_W-1:0] value);
        @(posedge clk);
        text_attribute_we   <= 1'b1;
        text_attribute_data <= value;
        @(posedge clk);
        text_attribute_we   <= 1'b0;
        shadow_attr = value;
        attr_count++;
    endtask

    task automatic queue_burst(int unsigned n, int unsigned nl_pct);
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        for (int i = 0; i < n; i++)
        begin
            ch  = CHAR_W'($urandom_range(255));
            idx = IDX_W'($urandom_range(2047));
            if ($urandom_range(99) < 35)
            begin
                if ($urandom_range(99) < 85)
                    idx = IDX_W'($urandom_range(CELL_COUNT - 1));
                else
                    idx = IDX_W'($urandom_range(2047, CELL_COUNT));
                queue_request(OP_READ, ch, idx);
            end
            else
            begin
                if ($urandom_range(99) < nl_pct)
                    ch = NEWLINE_CODE;
                queue_request(OP_WRITE, ch, idx);
            end
        end
    endtask

    initial
    begin
        int unsigned nl_mix [3];
        nl_mix = '{5, 25, 90};
        for (int k = 0; k < CELL_COUNT; k++)
            shadow_screen[k] = BLANK_CELL;
        shadow_cursor = 0;
        shadow_attr   = ATTR_RESET;
        send_idle_pct = 8;
        recv_idle_pct = 87;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset attribute, extreme codes, newline cases, both scroll kinds
        queue_request(OP_READ, 8'h00, IDX_W'(CELL_COUNT - 1));
        queue_request(OP_WRITE, 8'h00, '0);
        queue_request(OP_WRITE, 8'hFF, '1);
        queue_request(OP_READ, 8'hFF, IDX_W'(0));
        queue_request(OP_READ, 8'h00, IDX_W'(1));
        queue_request(OP_WRITE, NEWLINE_CODE, '0);
        queue_request(OP_WRITE, NEWLINE_CODE, '0);
        repeat (ROWS - 2) queue_request(OP_WRITE, NEWLINE_CODE, '0);
        queue_request(OP_WRITE, 8'h41, '0);
        queue_request(OP_READ, 8'h00, IDX_W'(CELL_COUNT - COLUMNS));
        queue_request(OP_WRITE, NEWLINE_CODE, '0);
        queue_request(OP_WRITE, NEWLINE_CODE, '0);
        queue_request(OP_READ, 8'h00, IDX_W'(0));
        queue_request(OP_READ, 8'h00, IDX_W'(CELL_COUNT - 2 * COLUMNS));
        queue_request(OP_READ, 8'h00, IDX_W'(CELL_COUNT));
        queue_request(OP_READ, 8'h00, '1);
        drain();

        for (int b = 0; b < BURSTS; b++)
        begin
            if (b == BURSTS / 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 8;
            end
            else if (b == 2 * BURSTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (b == 0)
                set_attribute(8'h00);
            else if (b == 1)
                set_attribute(8'hFF);
            else if (b % 2 == 0)
                set_attribute(ATTR_W'($urandom_range(255)));
            queue_burst(BURST_LEN, nl_mix[b % 3]);
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d character writes, %0d newlines, %0d reads (%0d past the screen)",
                 write_count, newline_count, read_count, oob_count);
        $display("with %0d scrolls and %0d attribute settings", scroll_count, attr_count);
        if (error_count == 0)
            $display("text_console_writer_top_tb passed");
        else
            $display("text_console_writer_top_tb failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Timed out with %0d requests and %0d replies outstanding",
                 console_req_q.size(), console_reply_q.size());
        $display("text_console_writer_top_tb failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer_top.sv
test/text_console_writer_top_tb.sv
